// ===== rtl/midi_message_encoder_macros.svh =====
// Assertion macros used by the back part of the MIDI message encoder.
`ifndef MIDI_MESSAGE_ENCODER_MACROS_SVH
`define MIDI_MESSAGE_ENCODER_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define MME_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define MME_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mme_pkg.sv =====
// Shared types and constants of the MIDI message encoder.
package mme_pkg;

    // Depth of the descriptor queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;

    // Request command codes.
    localparam logic [2:0] CMD_NOTE_ON  = 3'd0;
    localparam logic [2:0] CMD_NOTE_OFF = 3'd1;
    localparam logic [2:0] CMD_CTRL     = 3'd2;
    localparam logic [2:0] CMD_PROGRAM  = 3'd3;
    localparam logic [2:0] CMD_RPN      = 3'd4;
    localparam logic [2:0] CMD_NRPN     = 3'd5;
    localparam logic [2:0] CMD_SYSEX    = 3'd6;

    // Message kind carried from the front part to the back part.
    typedef enum logic [2:0] {
        KIND_NOTE_ON,
        KIND_NOTE_OFF,
        KIND_CTRL,
        KIND_PROGRAM,
        KIND_RPN,
        KIND_NRPN,
        KIND_SYSEX
    } msg_kind_t;

    // One request item.
    typedef struct packed {
        logic [2:0]  cmd;
        logic [6:0]  data_first;
        logic [6:0]  data_second;
        logic [6:0]  param_number_high;
        logic [31:0] sysex_address;
    } in_item_t;

    // One result item.
    typedef struct packed {
        logic [7:0] midi_byte;
        logic       last_byte;
    } out_item_t;

    // Classified message waiting to be sent.
    typedef struct packed {
        msg_kind_t   kind;
        logic [3:0]  last_idx;
        logic [6:0]  data_first;
        logic [6:0]  data_second;
        logic [6:0]  param_number_high;
        logic [31:0] sysex_address;
        logic [6:0]  checksum;
    } msg_desc_t;

endpackage

// ===== rtl/mme_front.sv =====
// Front part: accepts request items, classifies them and precomputes the checksum.
module mme_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  mme_pkg::in_item_t   in_item,
    output logic                q_wr_valid,
    input  logic                q_wr_ready,
    output mme_pkg::msg_desc_t  q_wr_data
);

    logic               valid_reg;
    logic               valid_next;
    mme_pkg::msg_desc_t desc_reg;
    mme_pkg::msg_desc_t desc_next;
    mme_pkg::msg_desc_t desc_class;
    logic               cmd_known;
    logic [6:0]         sum7;
    logic               accept;
    logic               drain;

    // The stage is full only while its item cannot move into the queue.
    assign drain      = valid_reg && q_wr_ready;
    assign full       = valid_reg && !q_wr_ready;
    assign accept     = push && !full;
    assign q_wr_valid = valid_reg;
    assign q_wr_data  = desc_reg;

    // Checksum over the low seven bits of each address byte and the value.
    always_comb
    begin
        sum7 = in_item.sysex_address[30:24] + in_item.sysex_address[22:16]
             + in_item.sysex_address[14:8] + in_item.sysex_address[6:0]
             + in_item.data_second;
    end

    // Command decode into message kind and last byte index.
    always_comb
    begin
        desc_class.data_first        = in_item.data_first;
        desc_class.data_second       = in_item.data_second;
        desc_class.param_number_high = in_item.param_number_high;
        desc_class.sysex_address     = in_item.sysex_address;
        desc_class.checksum          = 7'd0 - sum7;
        cmd_known                    = 1'b1;
        unique case (in_item.cmd)
            mme_pkg::CMD_NOTE_ON:
            begin
                desc_class.kind     = mme_pkg::KIND_NOTE_ON;
                desc_class.last_idx = 4'd2;
            end
            mme_pkg::CMD_NOTE_OFF:
            begin
                desc_class.kind     = mme_pkg::KIND_NOTE_OFF;
                desc_class.last_idx = 4'd2;
            end
            mme_pkg::CMD_CTRL:
            begin
                desc_class.kind     = mme_pkg::KIND_CTRL;
                desc_class.last_idx = 4'd2;
            end
            mme_pkg::CMD_PROGRAM:
            begin
                desc_class.kind     = mme_pkg::KIND_PROGRAM;
                desc_class.last_idx = 4'd1;
            end
            mme_pkg::CMD_RPN:
            begin
                desc_class.kind     = mme_pkg::KIND_RPN;
                desc_class.last_idx = 4'd8;
            end
            mme_pkg::CMD_NRPN:
            begin
                desc_class.kind     = mme_pkg::KIND_NRPN;
                desc_class.last_idx = 4'd8;
            end
            mme_pkg::CMD_SYSEX:
            begin
                desc_class.kind     = mme_pkg::KIND_SYSEX;
                desc_class.last_idx = 4'd12;
            end
            default:
            begin
                desc_class.kind     = mme_pkg::KIND_NOTE_ON;
                desc_class.last_idx = 4'd0;
                cmd_known           = 1'b0;
            end
        endcase
    end

    // Stage register update; an unknown command is dropped here.
    always_comb
    begin
        valid_next = valid_reg;
        desc_next  = desc_reg;
        if (accept)
        begin
            valid_next = cmd_known;
            desc_next  = desc_class;
        end
        else if (drain)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        desc_reg <= desc_next;
    end

endmodule

// ===== rtl/mme_queue.sv =====
// Short descriptor queue between the front and back parts.
module mme_queue
#(
    parameter int Depth = mme_pkg::QUEUE_DEPTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_valid,
    output logic                wr_ready,
    input  mme_pkg::msg_desc_t  wr_data,
    output logic                rd_valid,
    input  logic                rd_ready,
    output mme_pkg::msg_desc_t  rd_data
);

    localparam int PtrW = $clog2(Depth);
    localparam int CntW = $clog2(Depth + 1);

    mme_pkg::msg_desc_t mem [Depth];
    logic [PtrW-1:0]    wr_ptr_reg;
    logic [PtrW-1:0]    wr_ptr_next;
    logic [PtrW-1:0]    rd_ptr_reg;
    logic [PtrW-1:0]    rd_ptr_next;
    logic [CntW-1:0]    count_reg;
    logic [CntW-1:0]    count_next;
    logic               do_wr;
    logic               do_rd;

    assign wr_ready = (count_reg != CntW'(Depth));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    // Pointer and fill count update with explicit wrap.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== rtl/mme_back.sv =====
// Back part: emits a classified message one byte per cycle unless the output stalls.
`include "midi_message_encoder_macros.svh"

module mme_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [3:0]          midi_channel,
    input  logic                q_rd_valid,
    output logic                q_rd_ready,
    input  mme_pkg::msg_desc_t  q_rd_data,
    output logic                empty,
    input  logic                pop,
    output mme_pkg::out_item_t  out_item
);

    localparam logic [7:0] ST_NOTE_ON  = 8'h90;
    localparam logic [7:0] ST_NOTE_OFF = 8'h80;
    localparam logic [7:0] ST_CTRL     = 8'hB0;
    localparam logic [7:0] ST_PROGRAM  = 8'hC0;
    localparam logic [7:0] SX_START    = 8'hF0;
    localparam logic [7:0] SX_MAKER    = 8'h41;
    localparam logic [7:0] SX_DEVICE   = 8'h10;
    localparam logic [7:0] SX_MODEL_HI = 8'h00;
    localparam logic [7:0] SX_MODEL_LO = 8'h03;
    localparam logic [7:0] SX_DATA_SET = 8'h12;
    localparam logic [7:0] SX_END      = 8'hF7;
    localparam logic [6:0] RPN_HI      = 7'd101;
    localparam logic [6:0] RPN_LO      = 7'd100;
    localparam logic [6:0] NRPN_HI     = 7'd99;
    localparam logic [6:0] NRPN_LO     = 7'd98;
    localparam logic [6:0] DATA_ENTRY  = 7'd6;

    logic               busy_reg;
    logic               busy_next;
    logic [3:0]         idx_reg;
    logic [3:0]         idx_next;
    mme_pkg::msg_desc_t desc_reg;
    mme_pkg::msg_desc_t desc_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    mme_pkg::out_item_t out_item_reg;
    mme_pkg::out_item_t out_item_next;
    logic               emit;
    logic               is_last;
    logic               emit_last;
    logic               load;
    logic [7:0]         cur_byte;
    logic [7:0]         cc_status;
    logic [6:0]         param_hi_ctl;
    logic [6:0]         param_lo_ctl;

    // Handshake between the sequencer, the queue and the output register.
    assign emit       = busy_reg && (!out_valid_reg || pop);
    assign is_last    = (idx_reg == desc_reg.last_idx);
    assign emit_last  = emit && is_last;
    assign q_rd_ready = !busy_reg || emit_last;
    assign load       = q_rd_valid && q_rd_ready;
    assign empty      = !out_valid_reg;
    assign out_item   = out_item_reg;

    assign cc_status    = ST_CTRL | {4'd0, midi_channel};
    assign param_hi_ctl = (desc_reg.kind == mme_pkg::KIND_RPN) ? RPN_HI : NRPN_HI;
    assign param_lo_ctl = (desc_reg.kind == mme_pkg::KIND_RPN) ? RPN_LO : NRPN_LO;

    // Byte selection for the current position within the message.
    always_comb
    begin
        cur_byte = 8'd0;
        unique case (desc_reg.kind)
            mme_pkg::KIND_NOTE_ON, mme_pkg::KIND_NOTE_OFF, mme_pkg::KIND_CTRL:
            begin
                case (idx_reg)
                    4'd0:
                    begin
                        if (desc_reg.kind == mme_pkg::KIND_NOTE_ON)
                        begin
                            cur_byte = ST_NOTE_ON | {4'd0, midi_channel};
                        end
                        else if (desc_reg.kind == mme_pkg::KIND_NOTE_OFF)
                        begin
                            cur_byte = ST_NOTE_OFF | {4'd0, midi_channel};
                        end
                        else
                        begin
                            cur_byte = cc_status;
                        end
                    end
                    4'd1:    cur_byte = {1'b0, desc_reg.data_first};
                    default: cur_byte = {1'b0, desc_reg.data_second};
                endcase
            end
            mme_pkg::KIND_PROGRAM:
            begin
                if (idx_reg == 4'd0)
                begin
                    cur_byte = ST_PROGRAM | {4'd0, midi_channel};
                end
                else
                begin
                    cur_byte = {1'b0, desc_reg.data_first};
                end
            end
            mme_pkg::KIND_RPN, mme_pkg::KIND_NRPN:
            begin
                case (idx_reg)
                    4'd0, 4'd3, 4'd6: cur_byte = cc_status;
                    4'd1:    cur_byte = {1'b0, param_hi_ctl};
                    4'd2:    cur_byte = {1'b0, desc_reg.param_number_high};
                    4'd4:    cur_byte = {1'b0, param_lo_ctl};
                    4'd5:    cur_byte = {1'b0, desc_reg.data_first};
                    4'd7:    cur_byte = {1'b0, DATA_ENTRY};
                    default: cur_byte = {1'b0, desc_reg.data_second};
                endcase
            end
            mme_pkg::KIND_SYSEX:
            begin
                case (idx_reg)
                    4'd0:    cur_byte = SX_START;
                    4'd1:    cur_byte = SX_MAKER;
                    4'd2:    cur_byte = SX_DEVICE;
                    4'd3:    cur_byte = SX_MODEL_HI;
                    4'd4:    cur_byte = SX_MODEL_LO;
                    4'd5:    cur_byte = SX_DATA_SET;
                    4'd6:    cur_byte = desc_reg.sysex_address[31:24];
                    4'd7:    cur_byte = desc_reg.sysex_address[23:16];
                    4'd8:    cur_byte = desc_reg.sysex_address[15:8];
                    4'd9:    cur_byte = desc_reg.sysex_address[7:0];
                    4'd10:   cur_byte = {1'b0, desc_reg.data_second};
                    4'd11:   cur_byte = {1'b0, desc_reg.checksum};
                    default: cur_byte = SX_END;
                endcase
            end
            default:
            begin
                cur_byte = 8'd0;
            end
        endcase
    end

    // Sequencer: a new message loads as the previous one sends its last byte.
    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        desc_next = desc_reg;
        if (load)
        begin
            busy_next = 1'b1;
            idx_next  = 4'd0;
            desc_next = q_rd_data;
        end
        else if (emit_last)
        begin
            busy_next = 1'b0;
        end
        else if (emit)
        begin
            idx_next = idx_reg + 4'd1;
        end
    end

    // Output register holds a byte until it is taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (emit)
        begin
            out_valid_next          = 1'b1;
            out_item_next.midi_byte = cur_byte;
            out_item_next.last_byte = is_last;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            idx_reg       <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        desc_reg     <= desc_next;
        out_item_reg <= out_item_next;
    end

    // The byte position never runs past the end of the message.
    `MME_ASSERT_SAME(a_idx_in_range, busy_reg, idx_reg <= desc_reg.last_idx, "byte index overran")
    // Finishing a message without a successor leaves the sequencer idle.
    `MME_ASSERT_NEXT(a_done_idle, emit_last && !load, !busy_reg, "sequencer stayed busy")
    // A system exclusive message always closes with its end byte.
    `MME_ASSERT_SAME(a_sysex_end, emit_last && desc_reg.kind == mme_pkg::KIND_SYSEX,
                     cur_byte == SX_END, "sysex did not close with end byte")
    // A new message never loads while the current one still has bytes to send.
    `MME_ASSERT_SAME(a_load_gap, load, !busy_reg || emit_last, "message loaded mid-sequence")

endmodule

// ===== rtl/midi_message_encoder.sv =====
// Top level of the MIDI message encoder.
// Usage: a request item enters on push/full/in_item; it is taken at a clock edge where
// push is high and full is low. Each request becomes a run of MIDI bytes on out_item,
// read like a queue: while empty is low the oldest byte is shown, and pop takes it.
// out_item.last_byte marks the final byte of a message. Unknown command 7 yields no bytes.
// Byte counts: note on, note off and control change 3; program change 2; RPN and NRPN
// writes 9; system exclusive data set 13.
// From its accepting edge on an idle block, the first byte of a request passes the
// descriptor queue write, the sequencer load and the output register before it shows.
// Throughput: the back sequencer emits one byte per cycle while the output register is
// free or popped; the next message loads in the cycle of the previous last byte. The front
// stage and a two-entry queue take further requests while the sequencer is busy.
// The channel register is written through cfg_wr_en/cfg_wr_data and should change only
// while the block is idle. Reset clears all control state, empties the queue and sets the
// channel to 0. When pop stays low the output byte holds, the sequencer stops, and full
// rises once the queue and the front stage are occupied.
module midi_message_encoder
#(
    parameter int QueueDepth = mme_pkg::QUEUE_DEPTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  mme_pkg::in_item_t   in_item,
    output logic                empty,
    input  logic                pop,
    output mme_pkg::out_item_t  out_item,
    input  logic                cfg_wr_en,
    input  logic [3:0]          cfg_wr_data
);

    logic [3:0]         channel_reg;
    logic               q_wr_valid;
    logic               q_wr_ready;
    mme_pkg::msg_desc_t q_wr_data;
    logic               q_rd_valid;
    logic               q_rd_ready;
    mme_pkg::msg_desc_t q_rd_data;

    // Channel register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_reg <= 4'd0;
        end
        else if (cfg_wr_en)
        begin
            channel_reg <= cfg_wr_data;
        end
    end

    mme_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .in_item    (in_item),
        .q_wr_valid (q_wr_valid),
        .q_wr_ready (q_wr_ready),
        .q_wr_data  (q_wr_data)
    );

    mme_queue
    #(
        .Depth (QueueDepth)
    )
    u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (q_wr_valid),
        .wr_ready (q_wr_ready),
        .wr_data  (q_wr_data),
        .rd_valid (q_rd_valid),
        .rd_ready (q_rd_ready),
        .rd_data  (q_rd_data)
    );

    mme_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .midi_channel (channel_reg),
        .q_rd_valid   (q_rd_valid),
        .q_rd_ready   (q_rd_ready),
        .q_rd_data    (q_rd_data),
        .empty        (empty),
        .pop          (pop),
        .out_item     (out_item)
    );

endmodule
